// File: hw/rtl/pmsc_pkg.sv
// constants and types shared by the motor speed controller
`default_nettype none

package pmsc_pkg;

   typedef logic [2:0] csr_index_type;

   // register indexes of the configuration port
   localparam csr_index_type REG_TARGET_RPM       = 3'd0;
   localparam csr_index_type REG_PROP_GAIN        = 3'd1;
   localparam csr_index_type REG_INTEG_GAIN       = 3'd2;
   localparam csr_index_type REG_DERIV_GAIN       = 3'd3;
   localparam csr_index_type REG_STALL_TIMEOUT_MS = 3'd4;
   localparam csr_index_type REG_PWM_LIMIT        = 3'd5;

   localparam logic [15:0] TARGET_RPM_RESET       = 16'd120;
   localparam logic [15:0] PROP_GAIN_RESET        = 16'd205;
   localparam logic [15:0] INTEG_GAIN_RESET       = 16'd166;
   localparam logic [15:0] DERIV_GAIN_RESET       = 16'd1024;
   localparam logic [15:0] STALL_TIMEOUT_MS_RESET = 16'd1500;
   localparam logic [15:0] PWM_LIMIT_RESET        = 16'd5000;

   // 60000 rpm*ms in Q.8
   localparam logic [23:0] SPEED_NUMERATOR_Q8 = 24'd15360000;
   localparam logic [23:0] RPM_MAX_Q8         = 24'hFFFFFF;

   localparam logic signed [31:0] SUM_MAX   = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SUM_MIN   = 32'sh80000000;
   localparam logic signed [31:0] STATE_RESET_Q8 = 32'sd256;

   localparam int DIV_STEPS = 24;
   localparam int MUL_STEPS = 3;

endpackage

`default_nettype wire

// File: hw/rtl/pid_motor_speed_control.sv
// pid speed controller: restoring divider, shared multiplier and output register
`default_nettype none

// One control tick in, one drive result out. The speed 60000/interval rpm is
// found by a restoring divider that produces one quotient bit per cycle, then
// the error, saturating integral and error change are formed, and the three
// PID terms pass one after another through a single 17x32 multiplier into a
// 51-bit accumulator. The divider is skipped when the motor is stalled (speed
// zero) or the interval is zero (speed at its maximum). req_stall is high while
// a tick is being worked on; a finished result waits in the output register, so
// the next tick may be taken before the previous result has been transferred.
// Configuration registers are to be written only while no tick is in flight;
// the user must keep to this, as the block itself does not enforce it.
module pid_motor_speed_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [15:0]           req_pulse_interval_ms,
   input  wire logic [15:0]           req_since_pulse_ms,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [15:0]                rsp_drive_value,
   output logic [23:0]                rsp_measured_rpm,
   output logic signed [24:0]         rsp_speed_error,
   output logic signed [31:0]         rsp_integral_value,
   output logic signed [25:0]         rsp_error_change,
   input  wire logic                  csr_write_enable,
   input  wire pmsc_pkg::csr_index_type csr_index,
   input  wire logic [15:0]           csr_write_data
);
   import pmsc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ERROR,
      ST_SUM,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] target_rpm_ff, target_rpm_in;
   logic [15:0] prop_gain_ff, prop_gain_in;
   logic [15:0] integ_gain_ff, integ_gain_in;
   logic [15:0] deriv_gain_ff, deriv_gain_in;
   logic [15:0] stall_timeout_ff, stall_timeout_in;
   logic [15:0] pwm_limit_ff, pwm_limit_in;

   logic signed [31:0] error_sum_ff, error_sum_in;
   logic signed [24:0] prev_error_ff, prev_error_in;

   logic [15:0]        interval_ff, interval_in;
   logic [23:0]        quot_ff, quot_in;
   logic [15:0]        rem_ff, rem_in;
   logic [4:0]         count_ff, count_in;
   logic signed [24:0] err_ff, err_in;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [25:0] change_ff, change_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [50:0] acc_ff, acc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_drive_ff, rsp_drive_in;
   logic [23:0]        rsp_rpm_ff, rsp_rpm_in;
   logic signed [24:0] rsp_err_ff, rsp_err_in;
   logic signed [31:0] rsp_sum_ff, rsp_sum_in;
   logic signed [25:0] rsp_change_ff, rsp_change_in;

   // divider step
   logic [16:0] rem_shift;
   logic        rem_ge;

   // error and integral
   logic signed [32:0] sum_wide;

   // shared multiplier
   logic [15:0]        mul_gain;
   logic signed [31:0] mul_operand;
   logic signed [48:0] mul_result;

   // drive clamp
   logic        acc_positive;
   logic [33:0] acc_whole;
   logic [15:0] drive_value;

   assign rem_shift = {rem_ff, quot_ff[23]};
   assign rem_ge    = rem_shift >= {1'b0, interval_ff};
   assign sum_wide  = {error_sum_ff[31], error_sum_ff} + 33'(err_ff);

   always_comb begin
      case (count_ff[1:0])
         2'd0: begin
            mul_gain    = prop_gain_ff;
            mul_operand = 32'(err_ff);
         end
         2'd1: begin
            mul_gain    = integ_gain_ff;
            mul_operand = sum_ff;
         end
         2'd2: begin
            mul_gain    = deriv_gain_ff;
            mul_operand = 32'(change_ff);
         end
         default: begin
            mul_gain    = '0;
            mul_operand = '0;
         end
      endcase
   end

   assign mul_result = $signed({1'b0, mul_gain}) * mul_operand;

   assign acc_positive = !acc_ff[50] && (acc_ff != '0);
   assign acc_whole    = acc_ff[49:16];
   always_comb begin
      if (!acc_positive) begin
         drive_value = '0;
      end else if (acc_whole > {18'd0, pwm_limit_ff}) begin
         drive_value = pwm_limit_ff;
      end else begin
         drive_value = acc_whole[15:0];
      end
   end

   always_comb begin
      state_in         = state_ff;
      target_rpm_in    = target_rpm_ff;
      prop_gain_in     = prop_gain_ff;
      integ_gain_in    = integ_gain_ff;
      deriv_gain_in    = deriv_gain_ff;
      stall_timeout_in = stall_timeout_ff;
      pwm_limit_in     = pwm_limit_ff;
      error_sum_in     = error_sum_ff;
      prev_error_in    = prev_error_ff;
      interval_in      = interval_ff;
      quot_in          = quot_ff;
      rem_in           = rem_ff;
      count_in         = count_ff;
      err_in           = err_ff;
      sum_in           = sum_ff;
      change_in        = change_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_drive_in     = rsp_drive_ff;
      rsp_rpm_in       = rsp_rpm_ff;
      rsp_err_in       = rsp_err_ff;
      rsp_sum_in       = rsp_sum_ff;
      rsp_change_in    = rsp_change_ff;

      if (csr_write_enable) begin
         case (csr_index)
            REG_TARGET_RPM:       target_rpm_in    = csr_write_data;
            REG_PROP_GAIN:        prop_gain_in     = csr_write_data;
            REG_INTEG_GAIN:       integ_gain_in    = csr_write_data;
            REG_DERIV_GAIN:       deriv_gain_in    = csr_write_data;
            REG_STALL_TIMEOUT_MS: stall_timeout_in = csr_write_data;
            REG_PWM_LIMIT:        pwm_limit_in     = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               interval_in = req_pulse_interval_ms;
               rem_in      = '0;
               count_in    = '0;
               if (req_since_pulse_ms > stall_timeout_ff) begin
                  quot_in  = '0;
                  state_in = ST_ERROR;
               end else if (req_pulse_interval_ms == '0) begin
                  quot_in  = RPM_MAX_Q8;
                  state_in = ST_ERROR;
               end else begin
                  quot_in  = SPEED_NUMERATOR_Q8;
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            // dividend bits shift out of the top of quot as quotient bits enter
            rem_in   = rem_ge ? 16'(rem_shift - {1'b0, interval_ff}) : rem_shift[15:0];
            quot_in  = {quot_ff[22:0], rem_ge};
            count_in = count_ff + 5'd1;
            if (count_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_ERROR;
            end
         end
         ST_ERROR: begin
            err_in   = $signed({1'b0, target_rpm_ff, 8'h00}) - $signed({1'b0, quot_ff});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_wide[32] != sum_wide[31]) begin
               sum_in = sum_wide[32] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_in = sum_wide[31:0];
            end
            change_in     = 26'(err_ff) - 26'(prev_error_ff);
            error_sum_in  = sum_in;
            prev_error_in = err_ff;
            acc_in        = '0;
            count_in      = '0;
            state_in      = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            // product of one term is added while the next term multiplies
            prod_in  = mul_result;
            if (count_ff != '0) begin
               acc_in = acc_ff + 51'(prod_ff);
            end
            count_in = count_ff + 5'd1;
            if (count_ff[1:0] == 2'(MUL_STEPS)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_drive_in  = drive_value;
               rsp_rpm_in    = quot_ff;
               rsp_err_in    = err_ff;
               rsp_sum_in    = sum_ff;
               rsp_change_in = change_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         count_ff         <= '0;
         target_rpm_ff    <= TARGET_RPM_RESET;
         prop_gain_ff     <= PROP_GAIN_RESET;
         integ_gain_ff    <= INTEG_GAIN_RESET;
         deriv_gain_ff    <= DERIV_GAIN_RESET;
         stall_timeout_ff <= STALL_TIMEOUT_MS_RESET;
         pwm_limit_ff     <= PWM_LIMIT_RESET;
         error_sum_ff     <= STATE_RESET_Q8;
         prev_error_ff    <= 25'(STATE_RESET_Q8);
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         count_ff         <= count_in;
         target_rpm_ff    <= target_rpm_in;
         prop_gain_ff     <= prop_gain_in;
         integ_gain_ff    <= integ_gain_in;
         deriv_gain_ff    <= deriv_gain_in;
         stall_timeout_ff <= stall_timeout_in;
         pwm_limit_ff     <= pwm_limit_in;
         error_sum_ff     <= error_sum_in;
         prev_error_ff    <= prev_error_in;
      end
      interval_ff   <= interval_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      err_ff        <= err_in;
      sum_ff        <= sum_in;
      change_ff     <= change_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_rpm_ff    <= rsp_rpm_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_change_ff <= rsp_change_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_value    = rsp_drive_ff;
   assign rsp_measured_rpm   = rsp_rpm_ff;
   assign rsp_speed_error    = rsp_err_ff;
   assign rsp_integral_value = rsp_sum_ff;
   assign rsp_error_change   = rsp_change_ff;

   a_drive_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_value <= pwm_limit_ff)
      else $error("drive value above pwm limit");

   a_error_matches_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_speed_error ==
         ($signed({1'b0, target_rpm_ff, 8'h00}) - $signed({1'b0, rsp_measured_rpm})))
      else $error("speed error does not match measured speed");

   a_integral_is_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (state_ff == ST_IDLE) |-> rsp_integral_value == error_sum_ff)
      else $error("reported integral differs from stored integral");

   a_divider_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> count_ff < 5'(DIV_STEPS))
      else $error("divider ran past its step count");

endmodule

`default_nettype wire
